[sv/sgs_pkg.sv]
// ---------------------------------------------------------------------------
// sgs_pkg
// Shared types and constants of the symbol generality selection block.
// ---------------------------------------------------------------------------
package sgs_pkg;

    localparam int CODE_W = 12;
    localparam int OCC_W  = 16;
    localparam int BEN_W  = 16;
    localparam int RANK_W = 16;
    localparam int FACT_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_SELECT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BENEVOLENCE_Q8    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GENEROSITY_RANK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USER_SYMBOL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_FACTOR        = 3'd4;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_ROTATE,
        OP_CLEAR
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_DRAIN,
        ST_SCAN,
        ST_PROD,
        ST_MIN,
        ST_EMIT
    } state_t;

endpackage

[sv/symbol_generality_select_top.sv]
// ---------------------------------------------------------------------------
// symbol_generality_select_top
// Per-symbol generality tables and least-general symbol selection.
// ---------------------------------------------------------------------------
// After reset the block sweeps both tables to zero, one entry per cycle, and
// accepts no transfer until that is done. An accumulate transfer reads both
// tables through their read ports and then writes the sums back through their
// write ports. The transfer that closes a clause of buffered symbols then
// occupies the block with table reads that feed the sort chain, a full
// rotation of the sort chain to find the measure at the generosity rank, the
// forming of the limit from a product and a minimum, and the delivery of
// the results, which the output side can stall. The symbol codes of a clause
// are kept in a chain of collection cells; on the closing transfer they are
// drained one a cycle, their two measures are read from the tables and
// inserted into a chain of sort cells ordered by the chosen measure, then the
// other measure, then the code. Results are emitted from the head of the sort
// chain while their measure stays at or below the limit; a clause with no
// selection yields a single result with the empty flag set.
// ---------------------------------------------------------------------------
module symbol_generality_select_top
    import sgs_pkg::*;
#(
    parameter int NUM_SYMBOLS       = 4096,
    parameter int MAX_QUERY_SYMBOLS = 32,
    parameter int COUNT_WIDTH       = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,  // symbol_code[11:0], occurrences[27:12], zero
    input  logic [0:0]            s_tuser,  // func
    input  logic                  s_tlast,  // last_symbol
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,  // selected_code[11:0], zero
    output logic [1:0]            m_tuser,  // empty_res, truncated
    output logic                  m_tlast,  // last_result
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = COUNT_WIDTH;
    localparam int AW    = $clog2(NUM_SYMBOLS);
    localparam int NQ    = MAX_QUERY_SYMBOLS;
    localparam int FW    = $clog2(NQ + 1);
    localparam int KW    = $clog2(NQ);
    localparam int KEY_W = 2 * CW + CODE_W;
    localparam int PW    = CW + BEN_W + 1;
    localparam int LW    = PW - 8;

    // Configuration registers.
    logic              meas_sel_reg;
    logic [BEN_W-1:0]  benevolence_reg;
    logic [RANK_W-1:0] gen_rank_reg;
    logic [CODE_W-1:0] first_user_reg;
    logic [FACT_W-1:0] add_factor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_sel_reg    <= 1'b0;
            benevolence_reg <= 16'd256;
            gen_rank_reg    <= 16'hffff;
            first_user_reg  <= '0;
            add_factor_reg  <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MEASURE_SELECT:    meas_sel_reg    <= cfg_data[0];
                CFG_BENEVOLENCE_Q8:    benevolence_reg <= cfg_data;
                CFG_GENEROSITY_RANK:   gen_rank_reg    <= cfg_data;
                CFG_FIRST_USER_SYMBOL: first_user_reg  <= cfg_data[CODE_W-1:0];
                CFG_ADD_FACTOR:        add_factor_reg  <= cfg_data[FACT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input fields.
    logic              in_func;
    logic [CODE_W-1:0] in_code;
    logic [OCC_W-1:0]  in_occ;
    logic              in_code_ok;

    assign in_func    = s_tuser[0];
    assign in_code    = s_tdata[CODE_W-1:0];
    assign in_occ     = s_tdata[CODE_W+OCC_W-1:CODE_W];
    assign in_code_ok = (32'(in_code) < NUM_SYMBOLS);

    // Control registers.
    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [AW-1:0]     acc_addr_reg, acc_addr_next;
    logic [OCC_W-1:0]  acc_occ_reg, acc_occ_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic [FW-1:0]     n_reg, n_next;
    logic              trunc_reg, trunc_next;
    logic [FW-1:0]     cnt_reg, cnt_next;
    logic [KW-1:0]     rot_reg, rot_next;
    logic              ins_pend_reg, ins_pend_next;
    logic signed [CW-1:0] aux_reg, aux_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [LW-1:0] limit_reg, limit_next;

    logic              ov_reg, ov_next;
    logic [CODE_W-1:0] oc_reg, oc_next;
    logic              oe_reg, oe_next;
    logic              ot_reg, ot_next;
    logic              ol_reg, ol_next;

    // Tables.
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [CW-1:0] occ_wdata, cls_wdata, occ_rdata, cls_rdata;

    sgs_ram #(.WIDTH(CW), .DEPTH(NUM_SYMBOLS)) u_occ_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (occ_wdata),
        .raddr (ram_raddr),
        .rdata (occ_rdata)
    );

    sgs_ram #(.WIDTH(CW), .DEPTH(NUM_SYMBOLS)) u_cls_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cls_wdata),
        .raddr (ram_raddr),
        .rdata (cls_rdata)
    );

    // Accumulate arithmetic: factor times occurrences, both wrapped to CW bits.
    logic signed [FACT_W+OCC_W:0] acc_prod;
    logic signed [CW-1:0]         acc_inc, acc_fact;

    assign acc_prod = $signed(add_factor_reg) * $signed({1'b0, acc_occ_reg});
    assign acc_inc  = CW'(acc_prod);
    assign acc_fact = CW'($signed(add_factor_reg));

    // Collection chain.
    cell_op_t          col_op;
    logic [CODE_W-1:0] col_code [NQ];
    logic [NQ-1:0]     col_match;

    genvar gi;
    generate
        for (gi = 0; gi < NQ; gi++)
        begin : g_col
            logic [CODE_W-1:0] prev_c, next_c;
            if (gi == 0)
            begin : g_first
                assign prev_c = in_code;
            end
            else
            begin : g_mid
                assign prev_c = col_code[gi-1];
            end
            if (gi == NQ - 1)
            begin : g_last
                assign next_c = '0;
            end
            else
            begin : g_nxt
                assign next_c = col_code[gi+1];
            end
            sgs_collect_cell u_cell (
                .clk        (clk),
                .op         (col_op),
                .prev_code  (prev_c),
                .next_code  (next_c),
                .probe_code (in_code),
                .code       (col_code[gi]),
                .match      (col_match[gi])
            );
        end
    endgenerate

    logic seen;
    always_comb
    begin
        seen = 1'b0;
        for (int i = 0; i < NQ; i++)
        begin
            if (col_match[i] && (FW'(i) < fill_reg))
            begin
                seen = 1'b1;
            end
        end
    end

    // Sort chain. The key orders signed measures by flipping their sign bits.
    cell_op_t             srt_op;
    logic [KEY_W-1:0]     ins_key;
    logic [CW-1:0]        prim_rd, sec_rd;
    logic [CODE_W-1:0]    ins_code_reg;
    logic [NQ-1:0]        srt_valid, srt_lt;
    logic [KEY_W-1:0]     srt_key [NQ];

    assign prim_rd = meas_sel_reg ? cls_rdata : occ_rdata;
    assign sec_rd  = meas_sel_reg ? occ_rdata : cls_rdata;
    assign ins_key = {~prim_rd[CW-1], prim_rd[CW-2:0], ~sec_rd[CW-1], sec_rd[CW-2:0],
                      ins_code_reg};

    generate
        for (gi = 0; gi < NQ; gi++)
        begin : g_srt
            logic             p_lt, p_v, n_v;
            logic [KEY_W-1:0] p_k, n_k;
            if (gi == 0)
            begin : g_first
                assign p_lt = 1'b1;
                assign p_v  = 1'b0;
                assign p_k  = '0;
            end
            else
            begin : g_mid
                assign p_lt = srt_lt[gi-1];
                assign p_v  = srt_valid[gi-1];
                assign p_k  = srt_key[gi-1];
            end
            assign n_v = srt_valid[(gi+1) % NQ];
            assign n_k = srt_key[(gi+1) % NQ];
            sgs_sort_cell #(.KEY_W(KEY_W)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (srt_op),
                .ins_key    (ins_key),
                .prev_lt    (p_lt),
                .prev_valid (p_v),
                .prev_key   (p_k),
                .next_valid (n_v),
                .next_key   (n_k),
                .valid      (srt_valid[gi]),
                .key        (srt_key[gi]),
                .lt         (srt_lt[gi])
            );
        end
    endgenerate

    // Head and second entry of the sort chain, primary measure and code.
    logic signed [CW-1:0] head_meas, second_meas;
    logic [CODE_W-1:0]    head_code;
    logic signed [LW-1:0] head_ext, second_ext;

    assign head_meas   = $signed({~srt_key[0][KEY_W-1], srt_key[0][KEY_W-2:KEY_W-CW]});
    assign second_meas = $signed({~srt_key[1][KEY_W-1], srt_key[1][KEY_W-2:KEY_W-CW]});
    assign head_code   = srt_key[0][CODE_W-1:0];
    assign head_ext    = LW'(head_meas);
    assign second_ext  = LW'(second_meas);

    logic [FW-1:0] rank_clamped;
    assign rank_clamped = (gen_rank_reg >= RANK_W'(n_reg)) ? (n_reg - 1'b1)
                                                           : FW'(gen_rank_reg);

    logic signed [LW-1:0] scaled, aux_ext;
    assign scaled  = LW'(prod_reg >>> 8);
    assign aux_ext = LW'(aux_reg);

    logic out_free;
    assign out_free = !ov_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        acc_addr_next = acc_addr_reg;
        acc_occ_next  = acc_occ_reg;
        fill_next     = fill_reg;
        ovf_next      = ovf_reg;
        n_next        = n_reg;
        trunc_next    = trunc_reg;
        cnt_next      = cnt_reg;
        rot_next      = rot_reg;
        ins_pend_next = 1'b0;
        aux_next      = aux_reg;
        prod_next     = prod_reg;
        limit_next    = limit_reg;
        ov_next       = ov_reg && !m_tready;
        oc_next       = oc_reg;
        oe_next       = oe_reg;
        ot_next       = ot_reg;
        ol_next       = ol_reg;
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = acc_addr_reg;
        ram_raddr     = AW'(in_code);
        occ_wdata     = occ_rdata + acc_inc;
        cls_wdata     = cls_rdata + acc_fact;
        col_op        = OP_HOLD;
        srt_op        = OP_HOLD;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                occ_wdata = '0;
                cls_wdata = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(NUM_SYMBOLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (!in_func)
                    begin
                        if (in_code_ok)
                        begin
                            acc_addr_next = AW'(in_code);
                            acc_occ_next  = in_occ;
                            state_next    = ST_ACC;
                        end
                    end
                    else
                    begin
                        if (in_code_ok && (in_code >= first_user_reg) && !seen)
                        begin
                            if (fill_reg < FW'(NQ))
                            begin
                                col_op    = OP_LOAD;
                                fill_next = fill_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        if (s_tlast)
                        begin
                            n_next     = fill_next;
                            trunc_next = ovf_next;
                            fill_next  = '0;
                            ovf_next   = 1'b0;
                            cnt_next   = '0;
                            srt_op     = OP_CLEAR;
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end

            ST_ACC:
            begin
                ram_we     = 1'b1;
                state_next = ST_IDLE;
            end

            ST_DRAIN:
            begin
                ram_raddr = AW'(col_code[0]);
                if (ins_pend_reg)
                begin
                    srt_op = OP_LOAD;
                end
                if (cnt_reg < n_reg)
                begin
                    col_op        = OP_ROTATE;
                    ins_pend_next = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                end
                else
                begin
                    rot_next   = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                srt_op = OP_ROTATE;
                if (FW'(rot_reg) == rank_clamped)
                begin
                    aux_next = head_meas;
                end
                rot_next = rot_reg + 1'b1;
                if (rot_reg == KW'(NQ - 1))
                begin
                    state_next = ST_PROD;
                end
            end

            ST_PROD:
            begin
                prod_next  = PW'(head_meas) * $signed({1'b0, benevolence_reg});
                state_next = ST_MIN;
            end

            ST_MIN:
            begin
                limit_next = (aux_ext < scaled) ? aux_ext : scaled;
                cnt_next   = '0;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ot_next = trunc_reg;
                    if ((n_reg != '0) && (head_ext <= limit_reg))
                    begin
                        oc_next  = head_code;
                        oe_next  = 1'b0;
                        ol_next  = (cnt_reg + 1'b1 == n_reg) || (second_ext > limit_reg);
                        srt_op   = OP_ROTATE;
                        cnt_next = cnt_reg + 1'b1;
                        if (ol_next)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        // Nothing qualifies: a single empty result closes the query.
                        oc_next    = '0;
                        oe_next    = 1'b1;
                        ol_next    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            n_reg        <= '0;
            trunc_reg    <= 1'b0;
            cnt_reg      <= '0;
            rot_reg      <= '0;
            ins_pend_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            fill_reg     <= fill_next;
            ovf_reg      <= ovf_next;
            n_reg        <= n_next;
            trunc_reg    <= trunc_next;
            cnt_reg      <= cnt_next;
            rot_reg      <= rot_next;
            ins_pend_reg <= ins_pend_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_addr_reg <= acc_addr_next;
        acc_occ_reg  <= acc_occ_next;
        ins_code_reg <= col_code[0];
        aux_reg      <= aux_next;
        prod_reg     <= prod_next;
        limit_reg    <= limit_next;
        oc_reg       <= oc_next;
        oe_reg       <= oe_next;
        ot_reg       <= ot_next;
        ol_reg       <= ol_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'b0000, oc_reg};
    assign m_tuser  = {ot_reg, oe_reg};
    assign m_tlast  = ol_reg;

endmodule

[sv/sgs_ram.sv]
// ---------------------------------------------------------------------------
// sgs_ram
// Generic memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module sgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/sgs_collect_cell.sv]
// ---------------------------------------------------------------------------
// sgs_collect_cell
// One slot of the clause collection chain: takes a new code from its left
// neighbor on append and hands its code to the left while draining.
// ---------------------------------------------------------------------------
module sgs_collect_cell
    import sgs_pkg::*;
(
    input  logic              clk,
    input  cell_op_t          op,
    input  logic [CODE_W-1:0] prev_code,
    input  logic [CODE_W-1:0] next_code,
    input  logic [CODE_W-1:0] probe_code,
    output logic [CODE_W-1:0] code,
    output logic              match
);

    logic [CODE_W-1:0] code_reg;

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:   code_reg <= prev_code;
            OP_ROTATE: code_reg <= next_code;
            default:   code_reg <= code_reg;
        endcase
    end

    assign code  = code_reg;
    assign match = (code_reg == probe_code);

endmodule

[sv/sgs_sort_cell.sv]
// ---------------------------------------------------------------------------
// sgs_sort_cell
// One slot of the insertion sort chain. Each cell compares the broadcast key
// with its own and either keeps its entry, takes the new key, or takes the
// entry of its left neighbor. It also rotates entries to the left and can be cleared.
// ---------------------------------------------------------------------------
module sgs_sort_cell
    import sgs_pkg::*;
#(
    parameter int KEY_W = 76
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cell_op_t         op,
    input  logic [KEY_W-1:0] ins_key,
    input  logic             prev_lt,
    input  logic             prev_valid,
    input  logic [KEY_W-1:0] prev_key,
    input  logic             next_valid,
    input  logic [KEY_W-1:0] next_key,
    output logic             valid,
    output logic [KEY_W-1:0] key,
    output logic             lt
);

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;

    assign lt = valid_reg && (key_reg < ins_key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            case (op)
                OP_CLEAR:  valid_reg <= 1'b0;
                OP_LOAD:
                begin
                    if (!lt)
                    begin
                        valid_reg <= prev_lt ? 1'b1 : prev_valid;
                    end
                end
                OP_ROTATE: valid_reg <= next_valid;
                default:   valid_reg <= valid_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                if (!lt)
                begin
                    key_reg <= prev_lt ? ins_key : prev_key;
                end
            end
            OP_ROTATE: key_reg <= next_key;
            default:   key_reg <= key_reg;
        endcase
    end

    assign valid = valid_reg;
    assign key   = key_reg;

endmodule

[verif/symbol_generality_select_top_tb.sv]
// ---------------------------------------------------------------------------
// symbol_generality_select_top_tb
// Self-checking bench for the symbol generality selection block.
// ---------------------------------------------------------------------------
// Accumulate and query transfers go in on the input stream. A predictor with
// its own copy of both tables computes the selection of every clause, and a
// scoreboard compares each output transfer with the oldest expected result.
// ---------------------------------------------------------------------------
module symbol_generality_select_top_tb
    import sgs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSYM = 4096;
    localparam int QDEPTH = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef enum logic {FN_ACCUM = 1'b0, FN_QUERY = 1'b1} func_t;

    typedef struct packed {
        logic [11:0] code;
        logic        empty;
        logic        trunc;
        logic        last;
    } selection_t;

    // Scoreboard: owns the predictor state and the queue of expected results.
    class selection_scoreboard;
        logic signed [31:0] occ_sum [NSYM];
        logic signed [31:0] cls_cnt [NSYM];
        logic [11:0]        clause_codes [$];
        bit                 clause_overflow;
        bit                 by_count;
        logic [15:0]        benevolence;
        logic [15:0]        gen_rank;
        logic [11:0]        first_user;
        logic signed [7:0]  factor;
        selection_t         pending [$];
        int                 mismatches;

        function void init();
            for (int i = 0; i < NSYM; i++)
            begin
                occ_sum[i] = 0;
                cls_cnt[i] = 0;
            end
            clause_codes.delete();
            clause_overflow = 0;
            by_count = 0;
            benevolence = 16'd256;
            gen_rank = 16'hffff;
            first_user = 0;
            factor = 8'sd1;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                CFG_MEASURE_SELECT:    by_count = val[0];
                CFG_BENEVOLENCE_Q8:    benevolence = val;
                CFG_GENEROSITY_RANK:   gen_rank = val;
                CFG_FIRST_USER_SYMBOL: first_user = val[11:0];
                CFG_ADD_FACTOR:        factor = val[7:0];
                default: ;
            endcase
        endfunction

        function logic signed [31:0] measure(logic [11:0] c, bit cnt);
            return cnt ? cls_cnt[c] : occ_sum[c];
        endfunction

        // True when symbol a sorts after symbol b.
        function bit ranks_after(logic [11:0] a, logic [11:0] b);
            logic signed [31:0] ma, mb;
            ma = measure(a, by_count);
            mb = measure(b, by_count);
            if (ma != mb) return ma > mb;
            ma = measure(a, !by_count);
            mb = measure(b, !by_count);
            if (ma != mb) return ma > mb;
            return a > b;
        endfunction

        function void note_input(func_t fn, logic [11:0] c, logic [15:0] occ, bit lst);
            logic signed [63:0] prod, limit, capm;
            logic [11:0] sorted [$];
            logic [11:0] v;
            int j, n, rank, cnt;
            bit seen;
            selection_t r;
            if (fn == FN_ACCUM)
            begin
                // Both operands at 32 bits so the product wraps like the tables do.
                occ_sum[c] = occ_sum[c] + 32'(factor) * $signed({16'd0, occ});
                cls_cnt[c] = cls_cnt[c] + 32'(factor);
                return;
            end
            if (c >= first_user)
            begin
                seen = 0;
                foreach (clause_codes[i])
                    if (clause_codes[i] == c) seen = 1;
                if (!seen)
                begin
                    if (clause_codes.size() < QDEPTH) clause_codes.push_back(c);
                    else clause_overflow = 1;
                end
            end
            if (!lst) return;
            sorted = clause_codes;
            n = sorted.size();
            for (int i = 1; i < n; i++)
            begin
                v = sorted[i];
                j = i;
                while (j > 0 && ranks_after(sorted[j-1], v))
                begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            cnt = 0;
            if (n > 0)
            begin
                // 32-bit measure times 16-bit factor fits in 64 bits, floor by >>>.
                prod = 64'(measure(sorted[0], by_count)) * $signed({48'd0, benevolence});
                limit = prod >>> 8;
                rank = (gen_rank >= n) ? n - 1 : gen_rank;
                capm = 64'(measure(sorted[rank], by_count));
                if (capm < limit) limit = capm;
                for (int i = 0; i < n; i++)
                begin
                    if (64'(measure(sorted[i], by_count)) > limit) break;
                    r = '{code: sorted[i], empty: 1'b0, trunc: clause_overflow, last: 1'b0};
                    pending.push_back(r);
                    cnt++;
                end
            end
            if (cnt == 0)
                pending.push_back('{code: 12'd0, empty: 1'b1, trunc: clause_overflow,
                                    last: 1'b1});
            else
                pending[pending.size()-1].last = 1'b1;
            clause_codes.delete();
            clause_overflow = 0;
        endfunction

        function void check_result(selection_t got);
            selection_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: code %0d empty %0b trunc %0b last %0b",
                             got.code, got.empty, got.trunc, got.last);
                return;
            end
            exp_r = pending.pop_front();
            if (got != exp_r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected code %0d empty %0b trunc %0b last %0b, %s",
                             exp_r.code, exp_r.empty, exp_r.trunc, exp_r.last,
                             $sformatf("got code %0d empty %0b trunc %0b last %0b",
                                       got.code, got.empty, got.trunc, got.last));
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;    // symbol_code[11:0], occurrences[27:12], zero
    logic [0:0]            s_tuser = '0;    // func
    logic                  s_tlast = 1'b0;  // last_symbol
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;         // selected_code[11:0], zero
    logic [1:0]            m_tuser;         // empty_res, truncated
    logic                  m_tlast;         // last_result
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    selection_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  stall_free = 0;    // receiver stalls are switched off for a stretch

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    symbol_generality_select_top i_dut (.*);

    // Every transfer on the output side is checked the edge it happens.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result('{code: m_tdata[11:0], empty: m_tuser[0], trunc: m_tuser[1],
                              last: m_tlast});
    end

    // The receiver stalls at random, with stretches of no stalls.
    always @(posedge clk)
    begin
        if (stall_free) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    // The watchdog ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results pending", sb.pending.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The register write is seen by the block at this edge; the predictor copy follows.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_register(idx, val);
    endtask

    // One input transfer; holds tvalid until the handshake completes.
    task automatic send_item(func_t fn, logic [11:0] c, logic [15:0] occ, bit lst);
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {4'd0, occ, c};
        s_tlast <= lst;
        do @(posedge clk); while (!s_tready);
        sb.note_input(fn, c, occ, lst);
    endtask

    // The sender works in bursts; between bursts tvalid drops for a while.
    int burst_left = 0;
    task automatic paced_item(func_t fn, logic [11:0] c, logic [15:0] occ, bit lst);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_item(fn, c, occ, lst);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        // The wait lets accumulates still in flight finish.
        repeat (8) @(posedge clk);
    endtask

    // A clause from a small pool of codes so that tables get real contents.
    task automatic random_clause(int pool_lo, int pool_hi, int maxlen);
        int len;
        len = $urandom_range(1, maxlen);
        for (int i = 0; i < len; i++)
            paced_item(FN_QUERY, 12'($urandom_range(pool_lo, pool_hi)), 16'($urandom),
                       i == len - 1);
    endtask

    task automatic random_accums(int pool_lo, int pool_hi, int cnt);
        for (int i = 0; i < cnt; i++)
            paced_item(FN_ACCUM, 12'($urandom_range(pool_lo, pool_hi)),
                       ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom_range(0, 40)),
                       $urandom_range(0, 1));
    endtask

    initial
    begin
        int lo;
        sb.init();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme fields, an empty clause, duplicates, the ignored range.
        send_item(FN_ACCUM, 12'd4095, 16'hffff, 1'b1);
        send_item(FN_ACCUM, 12'd0, 16'd0, 1'b0);
        send_item(FN_ACCUM, 12'd5, 16'd3, 1'b0);
        send_item(FN_QUERY, 12'd4095, 16'hffff, 1'b0);
        send_item(FN_QUERY, 12'd4095, 16'd0, 1'b0);
        send_item(FN_QUERY, 12'd5, 16'd0, 1'b0);
        send_item(FN_QUERY, 12'd0, 16'd0, 1'b1);
        wait_drained();
        write_register(CFG_FIRST_USER_SYMBOL, 16'd4095);
        send_item(FN_QUERY, 12'd100, 16'd0, 1'b1);      // empty selection
        send_item(FN_QUERY, 12'd4095, 16'd0, 1'b1);
        wait_drained();
        write_register(CFG_FIRST_USER_SYMBOL, 16'd0);
        // Buffer overflow: 34 distinct codes in one clause.
        for (int i = 0; i < 34; i++) send_item(FN_QUERY, 12'(i + 200), 16'd0, i == 33);
        wait_drained();

        // Random phases with different settings, the extremes among them.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_register(CFG_MEASURE_SELECT, 16'(ph & 1));
            write_register(CFG_BENEVOLENCE_Q8,
                           ph == 0 ? 16'hffff : ph == 1 ? 16'd0 : 16'($urandom_range(0, 1024)));
            write_register(CFG_GENEROSITY_RANK,
                           ph == 2 ? 16'd0 : ph == 3 ? 16'hffff : 16'($urandom_range(0, 40)));
            write_register(CFG_ADD_FACTOR,
                           ph == 4 ? 16'h80 : ph == 5 ? 16'h7f : 16'($urandom_range(0, 255)));
            lo = $urandom_range(0, 4080);
            write_register(CFG_FIRST_USER_SYMBOL, 16'(ph == 6 ? 0 : lo + $urandom_range(0, 3)));
            stall_free = (ph == 7);
            random_accums(lo, lo + 15, 6);
            for (int k = 0; k < 3; k++) random_clause(lo, lo + 15, 8);
            if (ph == 4) random_clause(0, 4095, 40);
            wait_drained();
        end

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
sv/sgs_pkg.sv
sv/sgs_ram.sv
sv/sgs_collect_cell.sv
sv/sgs_sort_cell.sv
sv/symbol_generality_select_top.sv
verif/symbol_generality_select_top_tb.sv
